// ===== hw/rtl/i2w_pkg.sv =====
// Shared types and word codes for the integer-to-word-tokens block.
package i2w_pkg;

  localparam int NUM_W    = 31;
  localparam int CODE_W   = 5;
  localparam int DIGITS   = 10;
  localparam int GROUPS   = 4;
  localparam int GRP_WORDS = 5;

  // word codes
  localparam logic [CODE_W-1:0] W_ZERO     = 5'd0;
  localparam logic [CODE_W-1:0] W_TEN      = 5'd10;
  localparam logic [CODE_W-1:0] W_TWENTY   = 5'd20;
  localparam logic [CODE_W-1:0] W_HUNDRED  = 5'd28;
  localparam logic [CODE_W-1:0] W_THOUSAND = 5'd29;
  localparam logic [CODE_W-1:0] W_MILLION  = 5'd30;
  localparam logic [CODE_W-1:0] W_BILLION  = 5'd31;

  // three-digit groups, most significant first
  localparam logic [1:0] G_BILLIONS  = 2'd0;
  localparam logic [1:0] G_MILLIONS  = 2'd1;
  localparam logic [1:0] G_THOUSANDS = 2'd2;
  localparam logic [1:0] G_UNITS     = 2'd3;

  typedef logic [3:0] digit_t;
  typedef logic [DIGITS-1:0][3:0] digits_t;
  typedef logic [CODE_W-1:0] code_t;

endpackage

// ===== hw/rtl/i2w_ifs.sv =====
// Valid/ready channel interfaces for numbers in and word codes out.
interface i2w_num_if import i2w_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;
  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface i2w_word_if import i2w_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] word_code;
  logic              last_word;
  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

// ===== hw/rtl/i2w_front.sv =====
// Front end: takes a number and converts it to ten BCD digits, two bits a cycle.
module i2w_front import i2w_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  i2w_num_if.sink       numbers,
  input  logic          q_full,
  output logic          q_push,
  output digits_t       q_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state;
  logic [3:0]  cnt;
  logic [31:0] bin;
  digits_t     bcd;
  digits_t     bcd_next;

  // add 3 to every digit of 5 or more, then shift one bit in
  function automatic digits_t dabble(input digits_t d, input logic b);
    digits_t a;
    for (int i = 0; i < DIGITS; i++) begin
      a[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
    end
    return digits_t'({a, b});
  endfunction

  always_comb begin
    bcd_next = dabble(dabble(bcd, bin[31]), bin[30]);
  end

  assign numbers.ready = (state == ST_IDLE);
  assign q_push = (state == ST_PUSH) && !q_full;
  assign q_data = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (numbers.valid) begin
            bin   <= {1'b0, numbers.number};
            bcd   <= '0;
            cnt   <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          bin <= {bin[29:0], 2'b00};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2w_queue.sv =====
// Small FIFO of converted digit sets between front and back.
module i2w_queue import i2w_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  digits_t push_data,
  output logic    full,
  input  logic    pop,
  output digits_t pop_data,
  output logic    empty
);

  // DEPTH must be a power of two, at least 2; pointers wrap on their own
  localparam int AW = $clog2(DEPTH);

  digits_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2w_back.sv =====
// Back end: walks nonzero digit groups; one word code a cycle unless stalled.
module i2w_back import i2w_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  digits_t  q_data,
  output logic     q_pop,
  i2w_word_if.source words
);

  logic        active;
  logic        zero_mode;
  digits_t     digits;
  logic [1:0]  grp;
  logic [2:0]  k;
  logic        out_valid;
  code_t       out_code;
  logic        out_last;

  digit_t      gh, gt, gu;
  code_t       w [GRP_WORDS];
  logic [2:0]  n;
  logic [3:0]  nz_cur;
  logic [3:0]  nz_head;
  logic        next_found;
  logic [1:0]  next_grp;
  logic        first_found;
  logic [1:0]  first_grp;
  logic        adv;
  logic        grp_end;

  // per-group nonzero flags; billions group holds only the top digit
  function automatic logic [3:0] group_nz(input digits_t d);
    logic [3:0] f;
    f[G_BILLIONS]  = (d[9] != '0);
    f[G_MILLIONS]  = ({d[8], d[7], d[6]} != '0);
    f[G_THOUSANDS] = ({d[5], d[4], d[3]} != '0);
    f[G_UNITS]     = ({d[2], d[1], d[0]} != '0);
    return f;
  endfunction

  always_comb begin
    case (grp)
      G_BILLIONS:  begin gh = '0;     gt = '0;     gu = digits[9]; end
      G_MILLIONS:  begin gh = digits[8]; gt = digits[7]; gu = digits[6]; end
      G_THOUSANDS: begin gh = digits[5]; gt = digits[4]; gu = digits[3]; end
      default:     begin gh = digits[2]; gt = digits[1]; gu = digits[0]; end
    endcase
  end

  // compacted word list of the current group
  always_comb begin
    for (int i = 0; i < GRP_WORDS; i++) begin
      w[i] = W_ZERO;
    end
    n = '0;
    if (gh != '0) begin
      w[n] = {1'b0, gh};
      n = n + 3'd1;
      w[n] = W_HUNDRED;
      n = n + 3'd1;
    end
    if (gt >= 4'd2) begin
      w[n] = {1'b0, gt} + W_TWENTY - 5'd2;
      n = n + 3'd1;
      if (gu != '0) begin
        w[n] = {1'b0, gu};
        n = n + 3'd1;
      end
    end else if (gt == 4'd1) begin
      w[n] = W_TEN + {1'b0, gu};
      n = n + 3'd1;
    end else if (gu != '0) begin
      w[n] = {1'b0, gu};
      n = n + 3'd1;
    end
    case (grp)
      G_BILLIONS:  begin w[n] = W_BILLION;  n = n + 3'd1; end
      G_MILLIONS:  begin w[n] = W_MILLION;  n = n + 3'd1; end
      G_THOUSANDS: begin w[n] = W_THOUSAND; n = n + 3'd1; end
      default:     n = n;
    endcase
  end

  always_comb begin
    nz_cur     = group_nz(digits);
    nz_head    = group_nz(q_data);
    next_found = 1'b0;
    next_grp   = G_UNITS;
    first_found = 1'b0;
    first_grp   = G_BILLIONS;
    for (int i = 0; i < GROUPS; i++) begin
      if (!next_found && (2'(i) > grp) && nz_cur[i]) begin
        next_found = 1'b1;
        next_grp   = 2'(i);
      end
      if (!first_found && nz_head[i]) begin
        first_found = 1'b1;
        first_grp   = 2'(i);
      end
    end
  end

  assign adv     = active && (!out_valid || words.ready);
  assign grp_end = (k == n - 3'd1);
  assign q_pop   = !active && !q_empty;

  assign words.valid     = out_valid;
  assign words.word_code = out_code;
  assign words.last_word = out_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      digits <= q_data;
      grp    <= first_grp;
      zero_mode <= !first_found;
    end else if (adv && !zero_mode && grp_end && next_found) begin
      grp <= next_grp;
    end
    if (adv) begin
      if (zero_mode) begin
        out_code <= W_ZERO;
        out_last <= 1'b1;
      end else begin
        out_code <= w[k];
        out_last <= grp_end && !next_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
        k      <= '0;
      end else if (adv) begin
        if (zero_mode || (grp_end && !next_found)) begin
          active <= 1'b0;
        end else if (grp_end) begin
          k <= '0;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/integer_to_word_tokens_unit.sv =====
// Top level of the integer-to-word-tokens block: front, queue and back wired together.
//
// Usage:
//   numbers (sink): one 31-bit unsigned integer per transfer.
//   words (source): the English reading as word codes, most significant word
//   first, one code per transfer; last_word marks the final code of a number.
//   Codes: 0-19 Zero..Nineteen, 20-27 Twenty..Ninety, 28 Hundred,
//   29 Thousand, 30 Million, 31 Billion. A zero input reads as Zero alone.
// Timing:
//   The front converts to BCD by double dabble, two bits a cycle: it accepts
//   an input only when idle, converts it, then hands the digits to the queue
//   and takes no new number until that hand-off; that conversion loop and a
//   full queue set the input rate. The back loads a digit set from the queue
//   and then emits one word a cycle while the receiver is ready (1 to 16
//   words per number).
//   A queue of QUEUE_DEPTH digit sets sits between the two halves, so the
//   front keeps converting while the back waits on a stalled receiver.
// Reset: synchronous, clears the front state, the queue and the output valid.
// Stall: while words.ready is low the current code holds in the output
//   register; the back stops, the queue fills, and then numbers.ready drops.
module integer_to_word_tokens_unit import i2w_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  i2w_num_if.sink     numbers,
  i2w_word_if.source  words
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  digits_t q_wdata;
  digits_t q_rdata;

  // number in, BCD digits out
  i2w_front u_front (
    .clk     (clk),
    .rst     (rst),
    .numbers (numbers),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // decouples conversion from word emission
  i2w_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // digit groups to word codes
  i2w_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .words   (words)
  );

endmodule

// ===== hw/rtl/i2w_checker.sv =====
// Port-level checks for the integer-to-word-tokens block, bound to its top level.
module i2w_checker import i2w_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_code,
  input logic              out_last
);

  // held output under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
    else $error("output changed while stalled");

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Zero only ever stands alone
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_code == W_ZERO) |-> out_last)
    else $error("Zero code not marked last");

  // front is busy converting right after taking a number
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

endmodule

bind integer_to_word_tokens_unit i2w_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (numbers.valid),
  .in_ready  (numbers.ready),
  .out_valid (words.valid),
  .out_ready (words.ready),
  .out_code  (words.word_code),
  .out_last  (words.last_word)
);

// ===== tb/tb_integer_to_word_tokens_unit.sv =====
// Self-checking testbench for the integer-to-word-tokens block.
`timescale 1ns / 100ps

module tb_integer_to_word_tokens_unit;
  import i2w_pkg::*;

  typedef logic [NUM_W-1:0] num_t;

  // one expected word of a reading
  typedef struct packed {
    code_t code;
    logic  last;
  } word_t;

  logic clk;
  logic rst;

  i2w_num_if  num_ch ();
  i2w_word_if word_ch ();

  integer_to_word_tokens_unit dut (
    .clk     (clk),
    .rst     (rst),
    .numbers (num_ch),
    .words   (word_ch)
  );

  // 12 ns period, low phase first so no edge sits at time zero
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Numbers waiting to be offered, and word codes still owed by the block,
  // oldest first.
  num_t  pending_nums[$];
  word_t words_due[$];

  int nums_queued   = 0;
  int nums_accepted = 0;
  int words_checked = 0;
  int errors        = 0;
  int in_stalls     = 0;   // cycles with a number offered but refused

  // traffic shaping, set per phase by the sequencer below
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;   // remaining cycles of a long receiver hold-off

  bit num_taken;           // a number transfer happened at the last rising edge

  // Word sequence for one number. Groups of three digits from the billions
  // down; each nonzero group reads as optional "<digit> Hundred", then either
  // one word for 1..19 or a tens word plus an optional units word, then its
  // scale word unless it is the units group. All-zero groups say nothing.
  function automatic void predict_reading(input num_t num);
    int unsigned v;
    int unsigned grp;
    int unsigned hund;
    int unsigned rest;
    int unsigned divs[GROUPS];
    code_t       scale[GROUPS];
    code_t       seq[$];
    v     = num;
    divs  = '{1000000000, 1000000, 1000, 1};
    scale = '{W_BILLION, W_MILLION, W_THOUSAND, W_ZERO};
    if (v == 0) begin
      seq.insert(seq.size(), W_ZERO);
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp  = (v / divs[g]) % 1000;
      hund = grp / 100;
      rest = grp % 100;
      if (hund != 0) begin
        seq.insert(seq.size(), code_t'(hund));
        seq.insert(seq.size(), W_HUNDRED);
      end
      if (rest >= 20) begin
        seq.insert(seq.size(), code_t'(W_TWENTY + code_t'(rest / 10) - code_t'(2)));
        if (rest % 10 != 0) begin
          seq.insert(seq.size(), code_t'(rest % 10));
        end
      end else if (rest != 0) begin
        seq.insert(seq.size(), code_t'(rest));
      end
      if (grp != 0 && g != int'(G_UNITS)) begin
        seq.insert(seq.size(), scale[g]);
      end
    end
    foreach (seq[i]) begin
      words_due.insert(words_due.size(),
                       word_t'{code: seq[i], last: (i == seq.size() - 1)});
    end
  endfunction

  // One three-digit group, biased toward the interesting shapes:
  // empty groups, teens, round hundreds and round tens.
  function automatic int unsigned random_group();
    int unsigned h;
    h = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 19);
      2:       return h * 100;
      3:       return h * 100 + $urandom_range(10, 19);
      4:       return h * 100 + $urandom_range(2, 9) * 10;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  task automatic queue_random(input int count);
    longint unsigned v;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom & 32'h7FFF_FFFF;   // flat over the whole field
        1: v = $urandom_range(0, 999);     // single group
        default: begin
          v = longint'($urandom_range(0, 2)) * 1000000000 +
              longint'(random_group()) * 1000000 +
              longint'(random_group()) * 1000 + random_group();
          if (v > 64'h7FFF_FFFF) begin
            v -= 1000000000;
          end
        end
      endcase
      pending_nums.insert(pending_nums.size(), num_t'(v));
      nums_queued++;
    end
  endtask

  // Sender pauses here: no new numbers until the block has said everything.
  task automatic wait_drained();
    while (nums_accepted != nums_queued || words_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Number driver. Inputs change on the falling edge; an offered number is
  // held until a transfer is seen at a rising edge.
  always @(negedge clk) begin
    if (rst) begin
      num_ch.valid <= 1'b0;
    end else if (!(num_ch.valid && !num_taken)) begin
      if (pending_nums.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        num_ch.valid  <= 1'b1;
        num_ch.number <= pending_nums.pop_front();
      end else begin
        num_ch.valid <= 1'b0;
      end
    end
  end

  // Word receiver: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (rst) begin
      word_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      word_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      word_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor and checker, sampling at the rising edge.
  always @(posedge clk) begin
    word_t exp_w;
    num_taken = 1'b0;
    if (!rst) begin
      if (num_ch.valid && num_ch.ready) begin
        num_taken = 1'b1;
        predict_reading(num_ch.number);
        nums_accepted++;
      end else if (num_ch.valid) begin
        in_stalls++;
      end
      if (word_ch.valid && word_ch.ready) begin
        words_checked++;
        if (words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word transfer: expected none, got code %0d last %0b",
                   $time, word_ch.word_code, word_ch.last_word);
        end else begin
          exp_w = words_due.pop_front();
          if (word_ch.word_code !== exp_w.code) begin
            errors++;
            $display("%0t: word_code mismatch: expected %0d, got %0d",
                     $time, exp_w.code, word_ch.word_code);
          end
          if (word_ch.last_word !== exp_w.last) begin
            errors++;
            $display("%0t: last_word mismatch: expected %0b, got %0b",
                     $time, exp_w.last, word_ch.last_word);
          end
        end
      end
    end
  end

  // Sequencer: directed numbers, then random phases with different traffic.
  initial begin
    num_t directed_nums[25];
    // extremes, every teen edge, round groups, the longest reading
    // (1,777,777,777 gives sixteen words) and alternating bit patterns
    directed_nums = '{
      31'd0, 31'd1, 31'd9, 31'd10, 31'd13, 31'd19, 31'd20, 31'd21, 31'd99,
      31'd100, 31'd101, 31'd110, 31'd119, 31'd999, 31'd1000, 31'd1001,
      31'd1000000, 31'd1000000000, 31'd1000000001, 31'd1001001001,
      31'd2000000000, 31'd2147483647, 31'd1777777777,
      31'h2AAA_AAAA, 31'h5555_5555};

    // every block input known from time zero
    rst           = 1'b1;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    word_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, free flowing
    foreach (directed_nums[i]) begin
      pending_nums.insert(pending_nums.size(), directed_nums[i]);
      nums_queued++;
    end
    wait_drained();

    // random, no idling on either side
    queue_random(95);
    wait_drained();

    // sender idle half the time
    send_idle_pct = 50;
    queue_random(95);
    wait_drained();

    // receiver stalling half the time
    send_idle_pct = 0;
    stall_pct     = 50;
    queue_random(95);
    wait_drained();

    // both sides idling lightly
    send_idle_pct = 13;
    stall_pct     = 13;
    queue_random(95);
    wait_drained();

    // receiver holds off long enough for the digit queue to fill and the
    // number input to back up, while the sender keeps offering
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_left = 600;
    queue_random(25);
    wait_drained();

    // let any stray words show up before the verdict
    repeat (40) @(negedge clk);

    $display("Run covered %0d numbers (25 directed) and %0d word codes", nums_accepted,
             words_checked);
    $display("across free, idle, stall and mixed traffic; input refused for %0d cycles.",
             in_stalls);
    if (errors == 0 && words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("%0t: timeout, %0d numbers accepted, %0d words still owed", $time,
             nums_accepted, words_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
